### rtl/core/fef_pkg.sv
// fef_pkg: shared types, constants and helpers of the frame envelope follower.
// No dependencies; imported by every module under rtl/core.
`timescale 1ns / 1ps

package fef_pkg;

  // defaults for the top-level parameters
  localparam int HISTORY_DEPTH_DEF = 8;
  localparam int SAMPLE_BITS_DEF   = 16;

  // fixed field widths
  localparam int OUT_W = 16;  // frame_mean / envelope
  localparam int LEN_W = 13;  // frame_length register
  localparam int POS_W = 12;  // samples taken in the current frame

  localparam logic [LEN_W-1:0] MAX_FRAME     = 13'd4096;
  localparam logic [LEN_W-1:0] FRAME_LEN_RST = 13'd735;

  typedef enum logic [2:0] {
    ST_ACCUM,      // taking samples
    ST_DIV_MEAN,   // accumulator / frame length
    ST_ENV_START,  // history sum settled, start second division
    ST_DIV_ENV,    // history sum / depth
    ST_WAIT_OUT    // result ready, output register still occupied
  } fef_state_e;

  typedef struct packed {
    logic busy;
    logic done;   // one-cycle pulse, quotient valid
  } fef_div_sts_t;

  // zero counts as one, anything above the maximum saturates
  function automatic logic [LEN_W-1:0] fef_eff_len(logic [LEN_W-1:0] raw);
    logic [LEN_W-1:0] len;
    len = raw;
    if (raw == '0) begin
      len = LEN_W'(1);
    end else if (raw > MAX_FRAME) begin
      len = MAX_FRAME;
    end
    return len;
  endfunction

endpackage

### rtl/core/frame_envelope_follower.sv
// Frame envelope follower: mean absolute value per frame plus moving average.
// After the frame-closing request the serial divider runs twice (frame mean, then
//   history sum / depth) before the result is loaded into the output register.
// Throughput: one sample per cycle inside a frame; at each frame end the slave
//   side stalls while the divider runs and until the output register is free.
// Reset (rst_ni low, async): frame_length 735, accumulator, position and history zero.
`timescale 1ns / 1ps

module frame_envelope_follower import fef_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,  // 1..64
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF     // 8..24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration: frame_length
  input  logic                               cfg_wr_en_i,
  input  logic [LEN_W-1:0]                   cfg_wr_data_i,
  // sample stream; tdata: [SAMPLE_BITS-1:0] sample (signed), rest zero
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_axis_tdata,
  // result stream; tdata: [15:0] frame_mean, [31:16] envelope
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [2*OUT_W-1:0]                 m_axis_tdata
);

  // accumulator holds up to MAX_FRAME full-scale magnitudes
  localparam int ACC_W  = SAMPLE_BITS + POS_W;
  localparam int DIV_W  = ACC_W + (ACC_W % 2);          // divider takes 2 bits/cycle
  localparam int HIST_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 0;
  localparam int SUM_W  = SAMPLE_BITS + HIST_W;
  localparam logic [DIV_W-1:0] FULL_SCALE = DIV_W'(1) << (SAMPLE_BITS - 1);

  fef_state_e state_q, state_d;

  logic [LEN_W-1:0]       len_cfg_q;
  logic [LEN_W-1:0]       len_eff;
  logic [ACC_W-1:0]       acc_q, acc_d, acc_sum;
  logic [POS_W-1:0]       pos_q, pos_d;
  logic [LEN_W-1:0]       pos_inc;
  logic [SAMPLE_BITS-1:0] sample, mag;
  logic [SAMPLE_BITS-1:0] mean_q, mean_d;
  logic [DIV_W-1:0]       mean_sat, mean_ext;

  logic                   in_acc;
  logic                   frame_end;
  logic                   out_free;
  logic                   load_out;
  logic                   hist_push;
  logic [SUM_W-1:0]       hist_sum;

  logic                   div_start;
  logic [DIV_W-1:0]       div_dividend;
  logic [LEN_W-1:0]       div_divisor;
  fef_div_sts_t           div_sts;
  logic [DIV_W-1:0]       div_quot;

  logic                   out_valid_q;
  logic [OUT_W-1:0]       out_mean_q, out_env_q;

  // ---- configuration register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_cfg_q <= FRAME_LEN_RST;
    end else if (cfg_wr_en_i) begin
      len_cfg_q <= cfg_wr_data_i;
    end
  end

  assign len_eff = fef_eff_len(len_cfg_q);

  // ---- magnitude and frame accumulation ----
  assign sample  = s_axis_tdata[SAMPLE_BITS-1:0];
  // most negative sample maps to 2^(SAMPLE_BITS-1), full scale
  assign mag     = sample[SAMPLE_BITS-1] ? (~sample + SAMPLE_BITS'(1)) : sample;
  assign acc_sum = acc_q + ACC_W'(mag);
  assign pos_inc = LEN_W'(pos_q) + LEN_W'(1);
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  // ends also when the count already went past a shortened length
  assign frame_end = (pos_inc >= len_eff);

  // quotient may exceed full scale if frame_length dropped mid-frame
  assign mean_sat = (div_quot > FULL_SCALE) ? FULL_SCALE : div_quot;
  assign mean_ext = DIV_W'(mean_q);

  assign out_free = !out_valid_q || m_axis_tready;

  // ---- control ----
  always_comb begin
    state_d      = state_q;
    s_axis_tready = 1'b0;
    div_start    = 1'b0;
    div_dividend = DIV_W'(acc_sum);
    div_divisor  = len_eff;
    hist_push    = 1'b0;
    load_out     = 1'b0;
    acc_d        = acc_q;
    pos_d        = pos_q;
    mean_d       = mean_q;
    unique case (state_q)
      ST_ACCUM: begin
        // tready is high throughout this state
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (frame_end) begin
            div_start = 1'b1;
            acc_d     = '0;
            pos_d     = '0;
            state_d   = ST_DIV_MEAN;
          end else begin
            acc_d = acc_sum;
            pos_d = pos_inc[POS_W-1:0];
          end
        end
      end
      ST_DIV_MEAN: begin
        if (div_sts.done) begin
          mean_d    = mean_sat[SAMPLE_BITS-1:0];
          hist_push = 1'b1;
          state_d   = ST_ENV_START;
        end
      end
      ST_ENV_START: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(hist_sum);
        div_divisor  = LEN_W'(HISTORY_DEPTH);
        state_d      = ST_DIV_ENV;
      end
      ST_DIV_ENV: begin
        if (div_sts.done) begin
          if (out_free) begin
            load_out = 1'b1;
            state_d  = ST_ACCUM;
          end else begin
            state_d  = ST_WAIT_OUT;
          end
        end
      end
      ST_WAIT_OUT: begin
        // quotient register holds the envelope until the next start
        if (out_free) begin
          load_out = 1'b1;
          state_d  = ST_ACCUM;
        end
      end
      default: state_d = ST_ACCUM;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCUM;
      acc_q   <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mean_q <= mean_d;
  end

  // ---- output register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_mean_q <= mean_ext[OUT_W-1:0];
      out_env_q  <= div_quot[OUT_W-1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_env_q, out_mean_q};

  // ---- submodules ----
  fef_serial_div #(
    .DIV_W (DIV_W),
    .DVS_W (LEN_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .sts_o      (div_sts),
    .quotient_o (div_quot)
  );

  fef_history #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .ENT_W         (SAMPLE_BITS),
    .SUM_W         (SUM_W)
  ) u_hist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (hist_push),
    .mean_i (mean_d),
    .sum_o  (hist_sum)
  );

  // ---- assertions ----
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !div_sts.busy)
    else $error("sample request taken while divider busy");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> (state_q == ST_DIV_MEAN || state_q == ST_DIV_ENV))
    else $error("divider done outside a division state");

  a_mean_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ENV_START) |-> (mean_ext <= FULL_SCALE))
    else $error("frame mean above full scale");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!out_valid_q || m_axis_tready))
    else $error("result overwrote an unaccepted request");

endmodule

### rtl/core/fef_serial_div.sv
// fef_serial_div: restoring divider, two quotient bits per cycle.
// Depends on fef_pkg (status struct).
`timescale 1ns / 1ps

module fef_serial_div import fef_pkg::*; #(
  parameter int DIV_W = 28,  // dividend / quotient width, even
  parameter int DVS_W = 13   // divisor width
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DIV_W-1:0]   dividend_i,
  input  logic [DVS_W-1:0]   divisor_i,
  output fef_div_sts_t       sts_o,
  output logic [DIV_W-1:0]   quotient_o
);

  localparam int STEPS = DIV_W / 2;
  localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0] shreg_q, shreg_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;

  logic [DVS_W:0]   t1, t2, s1, s2;
  logic             q1, q2;
  logic [DVS_W-1:0] r1;

  // two dependent compare/subtract steps
  always_comb begin
    t1 = {rem_q, shreg_q[DIV_W-1]};
    s1 = t1 - {1'b0, dvs_q};
    q1 = (t1 >= {1'b0, dvs_q});
    r1 = q1 ? s1[DVS_W-1:0] : t1[DVS_W-1:0];
    t2 = {r1, shreg_q[DIV_W-2]};
    s2 = t2 - {1'b0, dvs_q};
    q2 = (t2 >= {1'b0, dvs_q});
  end

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    shreg_d = shreg_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    if (start_i && !busy_q) begin
      busy_d  = 1'b1;
      cnt_d   = CNT_W'(STEPS - 1);
      shreg_d = dividend_i;
      rem_d   = '0;
      dvs_d   = divisor_i;
    end else if (busy_q) begin
      shreg_d = {shreg_q[DIV_W-3:0], q1, q2};
      rem_d   = q2 ? s2[DVS_W-1:0] : t2[DVS_W-1:0];
      cnt_d   = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shreg_q <= shreg_d;
    rem_q   <= rem_d;
    dvs_q   <= dvs_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quotient_o = shreg_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q < dvs_q))
    else $error("partial remainder not below divisor");

endmodule

### rtl/core/fef_history.sv
// fef_history: shift line of recent frame means with a running sum.
// Depends on fef_pkg.
`timescale 1ns / 1ps

module fef_history import fef_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int ENT_W         = SAMPLE_BITS_DEF,
  parameter int SUM_W         = SAMPLE_BITS_DEF + 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [ENT_W-1:0] mean_i,
  output logic [SUM_W-1:0] sum_o
);

  logic [ENT_W-1:0] hist_q [HISTORY_DEPTH];
  logic [SUM_W-1:0] sum_q, sum_d;

  // oldest entry at index 0
  assign sum_d = sum_q - SUM_W'(hist_q[0]) + SUM_W'(mean_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_q[i] <= '0;
      end
      sum_q <= '0;
    end else if (push_i) begin
      for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
        hist_q[i] <= hist_q[i+1];
      end
      hist_q[HISTORY_DEPTH-1] <= mean_i;
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

### test/tb.sv
// tb: self-checking bench for frame_envelope_follower (frame mean plus moving envelope).
// Needs fef_pkg and the frame_envelope_follower RTL; stands alone otherwise.
// The result stream is checked against a built-in envelope predictor, with random backpressure.
`timescale 1ns / 1ps

module tb;
  import fef_pkg::*;

  localparam int HIST_N      = HISTORY_DEPTH_DEF;
  localparam int SMP_W       = SAMPLE_BITS_DEF;
  localparam int TDATA_W     = ((SMP_W + 7) / 8) * 8;
  localparam int SETTLE_CYC  = 48;  // settling margin for a frame-end division to finish
  localparam int RANDOM_ITEMS = 1150;
  localparam int MAX_SHOWN   = 10;

  localparam logic [27:0] FULL_SCALE = 28'd1 << (SMP_W - 1);

  // sample styles for the random phases
  typedef enum int {
    STY_ANY,       // full-range random
    STY_EXTREME,   // rails, zero and minus one
    STY_QUIET,     // small signal around zero
    STY_LOUD_NEG,  // mostly most-negative samples
    STY_MIXED
  } sample_style_e;

  typedef struct packed {
    logic [OUT_W-1:0] envelope;    // tdata [31:16]
    logic [OUT_W-1:0] frame_mean;  // tdata [15:0]
  } frame_result_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_wr_en_i   = 1'b0;
  logic [LEN_W-1:0]     cfg_wr_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [TDATA_W-1:0]   s_axis_tdata  = '0;  // [15:0] sample (signed)
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [2*OUT_W-1:0]   m_axis_tdata;        // [15:0] frame_mean, [31:16] envelope

  frame_envelope_follower dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_wr_en_i  (cfg_wr_en_i),
    .cfg_wr_data_i(cfg_wr_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // stimulus and expectation stores
  logic [TDATA_W-1:0] sample_q[$];
  frame_result_t      mean_env_q[$];

  // bookkeeping
  int mismatch_cnt  = 0;
  int samples_sent  = 0;
  int random_sent   = 0;
  int frames_seen   = 0;
  int len_writes    = 0;

  // idle control: percentage chance of starting an idle or stall burst
  int src_idle_pct  = 0;
  int sink_stall_pct = 0;
  int src_idle      = 0;
  int sink_stall    = 0;

  // ---------------------------------------------------------------------------
  // Envelope predictor: own copy of the register and the block state.
  // ---------------------------------------------------------------------------
  logic [LEN_W-1:0] frame_len_reg = FRAME_LEN_RST;
  logic [27:0]      abs_sum       = '0;
  logic [LEN_W-1:0] taken         = '0;  // one bit wider than the block, reaches 4096
  logic [OUT_W-1:0] history [HIST_N];
  logic [18:0]      history_total = '0;

  task automatic follow_envelope(input logic [SMP_W-1:0] smp);
    logic [LEN_W-1:0] len;
    logic [SMP_W:0]   mag;
    logic [27:0]      mean;
    frame_result_t    res;
    int               i;
    len = frame_len_reg;
    if (frame_len_reg == '0) begin
      len = LEN_W'(1);
    end else if (frame_len_reg > MAX_FRAME) begin
      len = MAX_FRAME;
    end
    // most-negative sample counts at full scale
    mag = smp[SMP_W-1] ? ((SMP_W+1)'(1) << SMP_W) - {1'b0, smp} : {1'b0, smp};
    abs_sum = abs_sum + 28'(mag);
    taken   = taken + LEN_W'(1);
    // frame closes once the count reaches or passes the current length
    if (taken >= len) begin
      mean = abs_sum / len;
      if (mean > FULL_SCALE) begin
        mean = FULL_SCALE;
      end
      history_total = history_total - 19'(history[0]) + 19'(mean[OUT_W-1:0]);
      for (i = 0; i < HIST_N - 1; i++) begin
        history[i] = history[i+1];
      end
      history[HIST_N-1] = mean[OUT_W-1:0];
      res.frame_mean = mean[OUT_W-1:0];
      res.envelope   = OUT_W'(history_total / HIST_N);
      mean_env_q.push_back(res);
      abs_sum = '0;
      taken   = '0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sample driver: each accepted request is fed to the predictor, then the
  // next queued sample goes out unless an idle burst is running.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        follow_envelope(s_axis_tdata[SMP_W-1:0]);
        samples_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_idle > 0) begin
          src_idle--;
          s_axis_tvalid <= 1'b0;
        end else if (sample_q.size() > 0) begin
          s_axis_tdata  <= sample_q.pop_front();
          s_axis_tvalid <= 1'b1;
          if ($urandom_range(0, 99) < src_idle_pct) begin
            src_idle = $urandom_range(1, 16);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(input string what, input int want, input int got);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_SHOWN) begin
      $display("%t  MISMATCH %s: expected %0d, got %0d", $realtime, what, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result monitor: compare every accepted result with the oldest expectation;
  // tready drops in random stall bursts.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    frame_result_t want;
    frame_result_t got;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        frames_seen++;
        if (mean_env_q.size() == 0) begin
          report_mismatch("unexpected result, frame_mean", -1, got.frame_mean);
        end else begin
          want = mean_env_q.pop_front();
          if (got.frame_mean !== want.frame_mean) begin
            report_mismatch("frame_mean", want.frame_mean, got.frame_mean);
          end
          if (got.envelope !== want.envelope) begin
            report_mismatch("envelope", want.envelope, got.envelope);
          end
        end
      end
      if (sink_stall > 0) begin
        sink_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 99) < sink_stall_pct) begin
          sink_stall = $urandom_range(1, 16);
        end
      end
    end
  end

  // wait until every sample went out and every expected result came back,
  // then give a frame-end division time to finish
  task automatic wait_idle();
    do begin
      @(posedge clk_i);
    end while (sample_q.size() != 0 || s_axis_tvalid || mean_env_q.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // frame_length is only written with the block idle
  task automatic set_frame_len(input logic [LEN_W-1:0] val);
    wait_idle();
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= val;
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    frame_len_reg = val;
    len_writes++;
  endtask

  function automatic logic [TDATA_W-1:0] rand_sample(input sample_style_e sty);
    logic [TDATA_W-1:0] v;
    v = TDATA_W'($urandom);
    case (sty)
      STY_EXTREME: begin
        case ($urandom_range(0, 3))
          0: v = 16'h8000;
          1: v = 16'h7FFF;
          2: v = 16'h0000;
          default: v = 16'hFFFF;
        endcase
      end
      STY_QUIET: begin
        v = TDATA_W'($urandom_range(0, 511) - 256);
      end
      STY_LOUD_NEG: begin
        if ($urandom_range(0, 3) != 0) begin
          v = 16'h8000;
        end
      end
      STY_MIXED: begin
        if ($urandom_range(0, 1) == 0) begin
          v = rand_sample(sample_style_e'($urandom_range(STY_EXTREME, STY_LOUD_NEG)));
        end
      end
      default: begin
      end
    endcase
    return v;
  endfunction

  function automatic int pick_idle_pct();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence: directed cases, random phases, oversized lengths with a
  // late shrink, and a final stretch without idling.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int          sel;
    int          len;
    int          cnt;
    int          eff;
    int          guard;
    sample_style_e sty;

    for (int i = 0; i < HIST_N; i++) begin
      history[i] = '0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct   = 10;
    sink_stall_pct = 10;

    // reset length 735: a partial frame with both rails and zero
    sample_q.push_back(16'h7FFF);
    sample_q.push_back(16'h8000);
    sample_q.push_back(16'h0000);
    // shrink the length mid-frame: next sample closes it, mean saturates
    set_frame_len(13'd2);
    sample_q.push_back(16'h8000);
    // zero length acts as one: every sample is a frame
    set_frame_len(13'd0);
    sample_q.push_back(16'h8000);
    sample_q.push_back(16'h7FFF);
    sample_q.push_back(16'hFFFF);
    sample_q.push_back(16'h0001);
    sample_q.push_back(16'h8001);
    sample_q.push_back(16'h4000);
    sample_q.push_back(16'h0000);
    set_frame_len(13'd1);
    sample_q.push_back(16'h5555);
    sample_q.push_back(16'hAAAA);
    // short frame whose sum divides evenly, then a partial one
    set_frame_len(13'd3);
    sample_q.push_back(16'd100);
    sample_q.push_back(16'hFF9C);
    sample_q.push_back(16'd7);
    sample_q.push_back(16'h7FFF);

    // random phases; oversized lengths only get short partial frames
    while (random_sent < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        len = 0;
      end else if (sel < 7) begin
        len = $urandom_range(1, 24);
      end else if (sel < 9) begin
        len = $urandom_range(25, 300);
      end else begin
        len = $urandom_range(4097, 8191);
      end
      eff = (len == 0) ? 1 : len;
      if (len > 300) begin
        cnt = $urandom_range(1, 40);
      end else if (len > 24) begin
        cnt = $urandom_range(1, eff + eff / 2 + 4);
      end else begin
        cnt = $urandom_range(1, 3 * eff + 8);
      end
      sty = sample_style_e'($urandom_range(STY_ANY, STY_MIXED));
      set_frame_len(LEN_W'(len));
      src_idle_pct   = pick_idle_pct();
      sink_stall_pct = pick_idle_pct();
      repeat (cnt) sample_q.push_back(rand_sample(sty));
      random_sent += cnt;
    end

    // long loud partial frame at 4096 and at the saturating register value,
    // then a shrink to one closes it with a saturated mean
    set_frame_len(MAX_FRAME);
    repeat (20) sample_q.push_back(16'h8000);
    set_frame_len(13'h1FFF);
    repeat (20) sample_q.push_back(16'h8000);
    set_frame_len(13'd1);
    sample_q.push_back(16'h8000);

    // last part: no idling on either side
    set_frame_len(LEN_W'($urandom_range(1, 8)));
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    repeat (200) sample_q.push_back(rand_sample(STY_ANY));

    // drain, bounded; anything still expected afterwards is a failure
    do begin
      @(posedge clk_i);
    end while (sample_q.size() != 0 || s_axis_tvalid);
    guard = 0;
    while (mean_env_q.size() != 0 && guard < 4000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (mean_env_q.size() != 0) begin
      report_mismatch("results never delivered", mean_env_q.size(), 0);
    end

    $display("Summary: %0d samples sent (%0d random), %0d frame results, %0d length writes",
             samples_sent, random_sent, frames_seen, len_writes);
    $display("Lengths covered zero, small, medium and oversized values, with bursty stalls");
    if (mismatch_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #20_000_000;
    $display("Timeout: run did not finish, %0d results still expected", mean_env_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### filelist.f
rtl/core/fef_pkg.sv
rtl/core/fef_serial_div.sv
rtl/core/fef_history.sv
rtl/core/frame_envelope_follower.sv
test/tb.sv
